@@ src/qtp_pkg.sv @@
`default_nettype none
package qtp_pkg;

    // Width of the divisor T^5 for a 24-bit duration.
    localparam int DEN_W   = 120;
    // Quotient bits resolved by each divider: enough to detect 64-bit overflow.
    localparam int QUO_W   = 65;
    // Divider depth: prepare stage, one stage per quotient bit, rounding stage.
    localparam int DIV_LAT = QUO_W + 2;

    // Numerator widths of the three quotients.
    localparam int PNUM_W  = 161;
    localparam int VNUM_W  = 162;
    localparam int ANUM_W  = 146;

    localparam logic [23:0] TOTAL_TIME_RST = 24'd1000;

    typedef enum logic [1:0] {
        PH_BEFORE = 2'd0,
        PH_WITHIN = 2'd1,
        PH_AFTER  = 2'd2
    } t_phase;

endpackage
`default_nettype wire

@@ src/qtp_div.sv @@
`default_nettype none
module qtp_div #(
    parameter int NUM_W = 161
) (
    input  logic                       i_clk,
    input  logic                       i_ce,
    input  logic [NUM_W-1:0]           i_num,
    input  logic [qtp_pkg::DEN_W-1:0]  i_den,
    output logic [qtp_pkg::QUO_W:0]    o_quo,
    output logic                       o_ovf
);
    import qtp_pkg::*;

    localparam int HW = NUM_W - QUO_W;
    localparam int CW = (HW > DEN_W) ? HW : DEN_W;

    logic [CW-1:0]    hi_x;
    logic [CW-1:0]    den_x;
    logic [DEN_W:0]   tw;
    logic             up;

    logic [DEN_W-1:0] r_rem [0:QUO_W];
    logic [QUO_W-1:0] r_low [0:QUO_W];
    logic [DEN_W-1:0] r_den [0:QUO_W];
    logic [QUO_W-1:0] r_q   [0:QUO_W];
    logic             r_ovf [0:QUO_W];

    assign hi_x  = CW'(i_num[NUM_W-1:QUO_W]);
    assign den_x = CW'(i_den);

    // Flag a quotient of 2^QUO_W or more; otherwise the high part is the first remainder.
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ovf[0] <= (hi_x >= den_x);
            r_rem[0] <= DEN_W'(hi_x);
            r_low[0] <= i_num[QUO_W-1:0];
            r_den[0] <= i_den;
            r_q[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_step
        logic [DEN_W:0] sh;
        logic [DEN_W:0] df;

        assign sh = {r_rem[k-1], r_low[k-1][QUO_W-k]};
        assign df = sh - {1'b0, r_den[k-1]};

        // Bring down one bit, subtract when it fits.
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k]          <= df[DEN_W] ? sh[DEN_W-1:0] : df[DEN_W-1:0];
                r_q[k]            <= r_q[k-1];
                r_q[k][QUO_W-k]   <= ~df[DEN_W];
                r_low[k]          <= r_low[k-1];
                r_den[k]          <= r_den[k-1];
                r_ovf[k]          <= r_ovf[k-1];
            end
        end
    end

    // Round to nearest, ties up.
    assign tw = {r_rem[QUO_W], 1'b0};
    assign up = (tw >= {1'b0, r_den[QUO_W]});

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_quo <= {1'b0, r_q[QUO_W]} + (QUO_W+1)'(up);
            o_ovf <= r_ovf[QUO_W];
        end
    end

endmodule

// Registered product of a wide and a short operand: 32-bit limb products,
// then their shifted sum.
module qtp_mul #(
    parameter int A_W = 58,
    parameter int B_W = 25,
    parameter int P_W = 83
) (
    input  logic           i_clk,
    input  logic           i_ce,
    input  logic [A_W-1:0] i_a,
    input  logic [B_W-1:0] i_b,
    output logic [P_W-1:0] o_p
);
    localparam int LIMB_N = (A_W + 31) / 32;
    localparam int PP_W   = 32 + B_W;

    logic [LIMB_N*32-1:0] a_x;
    logic [PP_W-1:0]      r_pp [0:LIMB_N-1];
    logic [P_W-1:0]       n_p;

    assign a_x = (LIMB_N*32)'(i_a);

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int j = 0; j < LIMB_N; j++) begin
                r_pp[j] <= PP_W'(a_x[j*32 +: 32]) * PP_W'(i_b);
            end
        end
    end

    // Add the limb products at their weights.
    always_comb begin
        n_p = '0;
        for (int j = 0; j < LIMB_N; j++) begin
            n_p = n_p + (P_W'(r_pp[j]) << (32 * j));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_p <= n_p;
        end
    end

endmodule
`default_nettype wire

@@ src/quintic_trajectory_point_core.sv @@
`default_nettype none
// Minimum-jerk (quintic) trajectory point for one joint.
//
// Input channel (i_in_valid / o_in_stall): time in ticks, start and end
// position. A transaction completes on a rising edge with valid high and
// stall low. Output channel (o_out_valid / i_out_stall): position (Q16.16),
// velocity per tick (Q16.40), acceleration per tick squared (Q16.48), phase.
// Config channel (i_cfg_valid / o_cfg_ready): duration in ticks; always
// ready, write it only while the core is empty.
//
// Throughput: one transaction per cycle unless a stalled result holds the
// pipeline. Nine stages build the numerators and T^5 (each wide product
// registers its limb products, then their sum), then three restoring
// dividers (one quotient bit per stage, 67 stages) and a saturation stage.
//
// The whole pipeline advances as one: when the output register holds a
// result that the receiver stalls, every stage holds and o_in_stall rises.
// Reset (synchronous, active low) empties the pipeline and sets the duration
// back to 1000 ticks.
module quintic_trajectory_point_core (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [23:0]        i_cfg_data,

    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_time_tick,
    input  logic signed [31:0] i_start_pos,
    input  logic signed [31:0] i_end_pos,

    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_position,
    output logic signed [55:0] o_velocity,
    output logic signed [63:0] o_acceleration,
    output logic [1:0]         o_phase
);
    import qtp_pkg::*;

    localparam int SIDE_N = 9 + DIV_LAT;

    typedef struct packed {
        t_phase             phase;
        logic signed [31:0] p0;
        logic signed [31:0] pt;
        logic               neg;
        logic               nega;
    } t_side;

    logic        ce;
    logic [23:0] r_total;
    logic [23:0] tt;

    logic        r_vld  [1:SIDE_N];
    t_side       r_side [1:SIDE_N];
    t_side       n_side;

    // stage 1 combinational terms
    logic               pre_start, post_end;
    logic [24:0]        ut, rem;
    logic signed [25:0] e;
    logic [25:0]        ae_w;
    logic signed [32:0] d;
    logic [32:0]        ad;

    logic [24:0]  r1_ut, r1_rem, r1_ae;
    logic [32:0]  r1_ad;
    logic [23:0]  r1_T;

    logic [57:0]  r2_at;
    logic [49:0]  r2_t2, r2_tT;
    logic [47:0]  r2_T2;
    logic [24:0]  r2_ut, r2_rem, r2_ae;
    logic [23:0]  r2_T;

    logic [52:0]  r3_qp, r4_qp, r5_qp, r6_qp;
    logic [24:0]  r3_ut, r3_rem, r3_ae;
    logic [24:0]  r4_ut, r4_rem, r4_ae;
    logic [24:0]  r5_rem, r6_rem;
    logic [23:0]  r3_T, r4_T, r5_T, r6_T;

    logic [82:0]  p4_at2, p4_atr;
    logic [71:0]  p4_T3;
    logic [107:0] p6_at3, p6_at2r, p6_atre;
    logic [95:0]  p6_T4;

    logic [134:0]     p8_pa;
    logic [133:0]     p8_pb;
    logic [132:0]     p8_vel;
    logic [DEN_W-1:0] p8_T5;
    logic [113:0]     r7_acc, r8_acc;

    logic [137:0] v30;
    logic [PNUM_W-1:0] r9_pnum;
    logic [VNUM_W-1:0] r9_vnum;
    logic [ANUM_W-1:0] r9_anum;
    logic [DEN_W-1:0]  r9_den;

    logic [QUO_W:0] pq, vq, aq;
    logic           po, vo, ao;

    // output stage
    t_side              so;
    logic signed [35:0] pos_w;
    logic signed [31:0] pos_sat;
    logic [QUO_W:0]     vlim, alim;
    logic [55:0]        vmag;
    logic [63:0]        amag;

    logic               r_out_valid;
    logic signed [31:0] r_out_pos;
    logic signed [55:0] r_out_vel;
    logic signed [63:0] r_out_acc;
    t_phase             r_out_phase;

    // Hold every stage while a finished result is stalled.
    assign ce          = ~(r_out_valid & i_out_stall);
    assign o_in_stall  = ~ce;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= TOTAL_TIME_RST;
        end else if (i_cfg_valid) begin
            r_total <= i_cfg_data;
        end
    end

    // A zero duration acts as one tick.
    assign tt = (r_total == '0) ? 24'd1 : r_total;

    // Stage 1: phase, |d|, t, T - t and |T - 2t|.
    always_comb begin
        pre_start = i_time_tick[31];
        post_end  = ~pre_start && (i_time_tick[30:0] > 31'(tt));
        ut        = i_time_tick[24:0];
        rem       = 25'(tt) - ut;
        e         = $signed(26'(tt)) - $signed({ut, 1'b0});
        ae_w      = e[25] ? 26'(-e) : 26'(e);
        d         = 33'(i_end_pos) - 33'(i_start_pos);
        ad        = d[32] ? 33'(-d) : 33'(d);

        n_side.phase = pre_start ? PH_BEFORE : (post_end ? PH_AFTER : PH_WITHIN);
        n_side.p0    = i_start_pos;
        n_side.pt    = i_end_pos;
        n_side.neg   = d[32];
        n_side.nega  = d[32] ^ e[25];
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_ut  <= ut;
            r1_rem <= rem;
            r1_ae  <= ae_w[24:0];
            r1_ad  <= ad;
            r1_T   <= tt;

            // Stage 2: first products.
            r2_at  <= 58'(r1_ad) * 58'(r1_ut);
            r2_t2  <= 50'(r1_ut) * 50'(r1_ut);
            r2_tT  <= 50'(r1_ut) * 50'(r1_T);
            r2_T2  <= 48'(r1_T) * 48'(r1_T);
            r2_ut  <= r1_ut;
            r2_rem <= r1_rem;
            r2_ae  <= r1_ae;
            r2_T   <= r1_T;

            // Stages 3 and 4: quadratic factor of the position; delay the
            // short operands beside the registered wide products.
            r3_qp  <= 53'(r2_T2) * 53'd10 + 53'(r2_t2) * 53'd6 - 53'(r2_tT) * 53'd15;
            r3_ut  <= r2_ut;
            r3_rem <= r2_rem;
            r3_ae  <= r2_ae;
            r3_T   <= r2_T;
            r4_qp  <= r3_qp;
            r4_ut  <= r3_ut;
            r4_rem <= r3_rem;
            r4_ae  <= r3_ae;
            r4_T   <= r3_T;

            // Stages 5 and 6
            r5_qp  <= r4_qp;
            r5_rem <= r4_rem;
            r5_T   <= r4_T;
            r6_qp  <= r5_qp;
            r6_rem <= r5_rem;
            r6_T   <= r5_T;

            // Stages 7 and 8: scale the acceleration term.
            r7_acc <= 114'(p6_atre) * 114'd60;
            r8_acc <= r7_acc;

            // Stage 9: finish numerators with their fixed-point scale.
            r9_pnum <= PNUM_W'(p8_pa) + (PNUM_W'(p8_pb) << 27);
            r9_vnum <= {v30, 24'b0};
            r9_anum <= {r8_acc, 32'b0};
            r9_den  <= p8_T5;
        end
    end

    // Stages 3-4: ad t^2, ad t (T - t), T^3.
    qtp_mul #(.A_W(58), .B_W(25), .P_W(83)) u_mul_at2 (
        .i_clk (i_clk), .i_ce (ce), .i_a (r2_at), .i_b (r2_ut), .o_p (p4_at2)
    );

    qtp_mul #(.A_W(58), .B_W(25), .P_W(83)) u_mul_atr (
        .i_clk (i_clk), .i_ce (ce), .i_a (r2_at), .i_b (r2_rem), .o_p (p4_atr)
    );

    qtp_mul #(.A_W(48), .B_W(24), .P_W(72)) u_mul_t3 (
        .i_clk (i_clk), .i_ce (ce), .i_a (r2_T2), .i_b (r2_T), .o_p (p4_T3)
    );

    // Stages 5-6: ad t^3, ad t^2 (T - t), ad t (T - t) |T - 2t|, T^4.
    qtp_mul #(.A_W(83), .B_W(25), .P_W(108)) u_mul_at3 (
        .i_clk (i_clk), .i_ce (ce), .i_a (p4_at2), .i_b (r4_ut), .o_p (p6_at3)
    );

    qtp_mul #(.A_W(83), .B_W(25), .P_W(108)) u_mul_at2r (
        .i_clk (i_clk), .i_ce (ce), .i_a (p4_at2), .i_b (r4_rem), .o_p (p6_at2r)
    );

    qtp_mul #(.A_W(83), .B_W(25), .P_W(108)) u_mul_atre (
        .i_clk (i_clk), .i_ce (ce), .i_a (p4_atr), .i_b (r4_ae), .o_p (p6_atre)
    );

    qtp_mul #(.A_W(72), .B_W(24), .P_W(96)) u_mul_t4 (
        .i_clk (i_clk), .i_ce (ce), .i_a (p4_T3), .i_b (r4_T), .o_p (p6_T4)
    );

    // Stages 7-8: split the quadratic factor into two partial products; also ad t^2 (T - t)^2 and T^5.
    qtp_mul #(.A_W(108), .B_W(27), .P_W(135)) u_mul_pa (
        .i_clk (i_clk), .i_ce (ce), .i_a (p6_at3), .i_b (r6_qp[26:0]), .o_p (p8_pa)
    );

    qtp_mul #(.A_W(108), .B_W(26), .P_W(134)) u_mul_pb (
        .i_clk (i_clk), .i_ce (ce), .i_a (p6_at3), .i_b (r6_qp[52:27]), .o_p (p8_pb)
    );

    qtp_mul #(.A_W(108), .B_W(25), .P_W(133)) u_mul_vel (
        .i_clk (i_clk), .i_ce (ce), .i_a (p6_at2r), .i_b (r6_rem), .o_p (p8_vel)
    );

    qtp_mul #(.A_W(96), .B_W(24), .P_W(DEN_W)) u_mul_t5 (
        .i_clk (i_clk), .i_ce (ce), .i_a (p6_T4), .i_b (r6_T), .o_p (p8_T5)
    );

    assign v30 = 138'(p8_vel) * 138'd30;

    qtp_div #(.NUM_W(PNUM_W)) u_div_pos (
        .i_clk (i_clk), .i_ce (ce), .i_num (r9_pnum), .i_den (r9_den),
        .o_quo (pq), .o_ovf (po)
    );

    qtp_div #(.NUM_W(VNUM_W)) u_div_vel (
        .i_clk (i_clk), .i_ce (ce), .i_num (r9_vnum), .i_den (r9_den),
        .o_quo (vq), .o_ovf (vo)
    );

    qtp_div #(.NUM_W(ANUM_W)) u_div_acc (
        .i_clk (i_clk), .i_ce (ce), .i_num (r9_anum), .i_den (r9_den),
        .o_quo (aq), .o_ovf (ao)
    );

    // Valid bits and sideband travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= SIDE_N; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (ce) begin
            r_vld[1] <= i_in_valid;
            for (int i = 2; i <= SIDE_N; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_side[1] <= n_side;
            for (int i = 2; i <= SIDE_N; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // Output stage: apply sign, saturate, pick the clamped ends.
    always_comb begin
        so    = r_side[SIDE_N];
        pos_w = so.neg ? (36'(so.p0) - 36'(pq[33:0])) : (36'(so.p0) + 36'(pq[33:0]));
        if ((po && !so.neg) || pos_w > 36'sh07FFFFFFF) begin
            pos_sat = 32'sh7FFFFFFF;
        end else if (po || pos_w < -36'sh080000000) begin
            pos_sat = -32'sh80000000;
        end else begin
            pos_sat = pos_w[31:0];
        end

        vlim = (QUO_W+1)'(1) << 55;
        if (!so.neg) begin
            vlim = vlim - (QUO_W+1)'(1);
        end
        vmag = (vo || vq > vlim) ? vlim[55:0] : vq[55:0];

        alim = (QUO_W+1)'(1) << 63;
        if (!so.nega) begin
            alim = alim - (QUO_W+1)'(1);
        end
        amag = (ao || aq > alim) ? alim[63:0] : aq[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ce) begin
            r_out_valid <= r_vld[SIDE_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_out_phase <= so.phase;
            case (so.phase)
                PH_WITHIN: begin
                    r_out_pos <= pos_sat;
                    r_out_vel <= so.neg ? -$signed(vmag) : $signed(vmag);
                    r_out_acc <= so.nega ? -$signed(amag) : $signed(amag);
                end
                PH_BEFORE: begin
                    r_out_pos <= so.p0;
                    r_out_vel <= '0;
                    r_out_acc <= '0;
                end
                default: begin
                    r_out_pos <= so.pt;
                    r_out_vel <= '0;
                    r_out_acc <= '0;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_position     = r_out_pos;
    assign o_velocity     = r_out_vel;
    assign o_acceleration = r_out_acc;
    assign o_phase        = r_out_phase;

    // Outside the duration the rates are zero.
    a_rest_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_phase != PH_WITHIN) |-> (o_velocity == '0 && o_acceleration == '0))
        else $error("nonzero rate outside the trajectory window");

    // A result leaving the last stage lands in the output register.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[SIDE_N] && ce) |=> o_out_valid)
        else $error("result lost between divider and output register");

    // Reset empties the output.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule
`default_nettype wire

@@ bench/tb_quintic_trajectory_point_core.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_quintic_trajectory_point_core;
    import qtp_pkg::*;

    typedef struct {
        logic signed [31:0] tick;
        logic signed [31:0] p_start;
        logic signed [31:0] p_end;
    } t_sample;

    typedef struct {
        logic signed [31:0] position;
        logic signed [55:0] velocity;
        logic signed [63:0] acceleration;
        t_phase             phase;
    } t_point;

    // Pipeline depth of the core, plus margin for the drain.
    localparam int PIPE_LAT  = 77;
    localparam int DRAIN_CYC = PIPE_LAT + 30;
    localparam int HANG_LIM  = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [23:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [31:0] i_time_tick = '0;
    logic signed [31:0] i_start_pos = '0;
    logic signed [31:0] i_end_pos = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [31:0] o_position;
    logic signed [55:0] o_velocity;
    logic signed [63:0] o_acceleration;
    logic [1:0] o_phase;

    t_sample pending_samples[$];
    t_point  expected_points[$];
    logic [23:0] duration = TOTAL_TIME_RST;
    int accepted_samples = 0;
    int mismatches = 0;
    int hang_cycles = 0;

    quintic_trajectory_point_core u_top (.*);

    always #5 i_clk = ~i_clk;

    // Round num/den to nearest with ties away from zero, then saturate to w bits.
    function automatic logic [63:0] sat_round(logic [255:0] num, logic [255:0] den,
                                              bit neg, int w);
        logic [255:0] q;
        logic [255:0] lim;
        logic [63:0]  v;
        q = (2 * num + den) / (2 * den);
        lim = (256'd1 << (w - 1)) - (neg ? 256'd0 : 256'd1);
        if (q > lim) q = lim;
        v = neg ? 64'd0 - q[63:0] : q[63:0];
        return v;
    endfunction

    // Minimum-jerk point for one sample, exact rational arithmetic.
    function automatic t_point min_jerk_point(t_sample s, logic [23:0] dur);
        t_point r;
        longint tt, tdur, d, e, pos;
        logic [255:0] ad, ut, ur, ae, den, num, q;
        logic [63:0] qp;
        tdur = (dur == 0) ? 1 : longint'(dur);
        tt = longint'(s.tick);
        r.velocity = '0;
        r.acceleration = '0;
        if (tt < 0) begin
            r.position = s.p_start;
            r.phase = PH_BEFORE;
            return r;
        end
        if (tt > tdur) begin
            r.position = s.p_end;
            r.phase = PH_AFTER;
            return r;
        end
        d = longint'(s.p_end) - longint'(s.p_start);
        e = tdur - 2 * tt;
        ad = 256'(d < 0 ? -d : d);
        ae = 256'(e < 0 ? -e : e);
        ut = 256'(tt);
        ur = 256'(tdur - tt);
        den = 256'(tdur);
        den = den * den * den * den * den;
        qp = 10 * tdur * tdur + 6 * tt * tt - 15 * tt * tdur;
        num = ad * ut * ut * ut * 256'(qp);
        q = (2 * num + den) / (2 * den);
        pos = d < 0 ? longint'(s.p_start) - longint'(q[63:0])
                    : longint'(s.p_start) + longint'(q[63:0]);
        if (pos > 64'sh7FFFFFFF) pos = 64'sh7FFFFFFF;
        if (pos < -64'sh80000000) pos = -64'sh80000000;
        r.position = pos[31:0];
        num = ad * (256'd30 << 24) * ut * ut * ur * ur;
        r.velocity = 56'(sat_round(num, den, d < 0, 56));
        num = ad * (256'd60 << 32) * ut * ur * ae;
        r.acceleration = sat_round(num, den, (d < 0) != (e < 0), 64);
        r.phase = PH_WITHIN;
        return r;
    endfunction

    // Idle pattern follows progress: sender light / receiver heavy, then the
    // reverse, then neither idles.
    function automatic bit sender_idle();
        if (accepted_samples < 630) return $urandom_range(0, 99) < 25;
        if (accepted_samples < 1260) return $urandom_range(0, 99) < 62;
        return 1'b0;
    endfunction

    function automatic bit receiver_idle();
        if (accepted_samples < 630) return $urandom_range(0, 99) < 62;
        if (accepted_samples < 1260) return $urandom_range(0, 99) < 25;
        return 1'b0;
    endfunction

    // Driver: record the expected point when a transaction completes, then
    // advance to the next pending sample or drop valid.
    always @(posedge i_clk) begin
        t_sample s;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                s.tick = i_time_tick;
                s.p_start = i_start_pos;
                s.p_end = i_end_pos;
                expected_points = {expected_points, min_jerk_point(s, duration)};
                accepted_samples++;
            end
            // Hold a stalled payload unchanged.
            if (!i_in_valid || !o_in_stall) begin
                if (pending_samples.size() > 0 && !sender_idle()) begin
                    s = pending_samples.pop_front();
                    i_in_valid <= 1'b1;
                    i_time_tick <= s.tick;
                    i_start_pos <= s.p_start;
                    i_end_pos <= s.p_end;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each completed result against the oldest expectation.
    always @(posedge i_clk) begin
        t_point x;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_points.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result pos=%h", o_position);
                end else begin
                    x = expected_points.pop_front();
                    if (o_position !== x.position || o_velocity !== x.velocity ||
                        o_acceleration !== x.acceleration || o_phase !== x.phase) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp %h %h %h %0d got %h %h %h %0d",
                                     x.position, x.velocity, x.acceleration, x.phase,
                                     o_position, o_velocity, o_acceleration, o_phase);
                    end
                end
            end
            i_out_stall <= receiver_idle();
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            hang_cycles <= 0;
        else
            hang_cycles <= hang_cycles + 1;
        if (hang_cycles >= HANG_LIM) begin
            $display("tb_quintic_trajectory_point_core: errors");
            $finish;
        end
    end

    function automatic logic signed [31:0] any_pos();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] any_tick(logic [23:0] dur);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return $urandom | 32'h80000000;
        if (r < 14) return 32'(dur) + 1 + $urandom_range(0, 1000);
        if (r < 17) return $urandom & 32'h7FFFFFFF;
        if (r < 19) return 32'sd0;
        if (r < 21) return 32'(dur);
        return $urandom_range(0, dur);
    endfunction

    task automatic add_sample(logic signed [31:0] tk, logic signed [31:0] a,
                              logic signed [31:0] b);
        t_sample s;
        s.tick = tk;
        s.p_start = a;
        s.p_end = b;
        pending_samples = {pending_samples, s};
    endtask

    // Drain everything, wait out the pipeline, then write the duration.
    task automatic set_duration(logic [23:0] val);
        wait (pending_samples.size() == 0 && expected_points.size() == 0 && !i_in_valid);
        repeat (DRAIN_CYC) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        duration = val;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [23:0] settings[5] = '{24'd1, 24'd16777215, 24'd7, 24'd1000, 24'd0};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: phase boundaries, extreme positions, sign of the acceleration.
        add_sample(-32'sd1, 32'sd100, 32'sd200);
        add_sample(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
        add_sample(32'sd0, 32'sd5, 32'sd999999);
        add_sample(32'sd1000, 32'sd5, 32'sd999999);
        add_sample(32'sd1001, 32'sd5, 32'sd999999);
        add_sample(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
        add_sample(32'sd500, 32'sh80000000, 32'sh7FFFFFFF);
        add_sample(32'sd500, 32'sh7FFFFFFF, 32'sh80000000);
        add_sample(32'sd250, 32'sh80000000, 32'sh7FFFFFFF);
        add_sample(32'sd750, 32'sh80000000, 32'sh7FFFFFFF);
        add_sample(32'sd250, 32'sh7FFFFFFF, 32'sh80000000);
        add_sample(32'sd750, 32'sh7FFFFFFF, 32'sh80000000);
        add_sample(32'sd1, 32'sd0, 32'sh7FFFFFFF);
        add_sample(32'sd999, 32'sd0, 32'sh80000000);
        add_sample(32'sd300, 32'sd42, 32'sd42);
        add_sample(32'sd600, 32'shFFFFFFFF, 32'sd0);
        for (int i = 0; i < 360; i++) add_sample(any_tick(duration), any_pos(), any_pos());

        for (int k = 0; k < 5; k++) begin
            set_duration(k == 4 ? 24'($urandom_range(2, 16777214)) : settings[k]);
            if (duration == 24'd1) begin
                add_sample(32'sd0, 32'sh80000000, 32'sh7FFFFFFF);
                add_sample(32'sd1, 32'sh80000000, 32'sh7FFFFFFF);
                add_sample(32'sd2, 32'sh80000000, 32'sh7FFFFFFF);
            end
            for (int i = 0; i < 305; i++)
                add_sample(any_tick(duration), any_pos(), any_pos());
        end

        wait (pending_samples.size() == 0 && expected_points.size() == 0 && !i_in_valid);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatches == 0 && expected_points.size() == 0)
            $display("tb_quintic_trajectory_point_core: clean");
        else
            $display("tb_quintic_trajectory_point_core: errors");
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
src/qtp_pkg.sv
src/qtp_div.sv
src/quintic_trajectory_point_core.sv
bench/tb_quintic_trajectory_point_core.sv
